// ===== hw/rtl/bpsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpsm_pkg
// Shared types and constants of the byte pattern stream matcher.
// ----------------------------------------------------------------------------
package bpsm_pkg;

    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int PIDX_W    = 6;
    localparam int LEN_W     = 7;
    localparam int OFFSET_W  = 48;
    localparam int COUNT_W   = 32;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = OFFSET_W + COUNT_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0]      LEN_RESET  = 7'd1;
    localparam logic [APB_ADDR_W-1:0] ADDR_PATTERN_LENGTH = 3'd0;
    localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_DATA    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    // one processed item, as seen by the store and the match vector
    typedef struct packed {
        logic             load;
        logic             data;
        logic             restart;
        logic             len_ok;
        logic [LEN_W-1:0] len;
    } step_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bpsm_pattern_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpsm_pattern_store
// Pattern byte registers with one byte comparator per position.
// ----------------------------------------------------------------------------
module bpsm_pattern_store #(
    parameter int PATTERN_MAX = 64
) (
    input  wire                              clk,
    input  wire bpsm_pkg::step_t             step,
    input  wire [bpsm_pkg::PIDX_W-1:0]       wr_index,
    input  wire [bpsm_pkg::BYTE_W-1:0]       byte_value,
    output logic [PATTERN_MAX-1:0]           eq
);

    logic [bpsm_pkg::BYTE_W-1:0] store_reg [PATTERN_MAX];

    // loads beyond the store never hit any position
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (step.load && (32'(wr_index) == 32'(i)))
            begin
                store_reg[i] <= byte_value;
            end
        end
    end

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
        assign eq[i] = (store_reg[i] == byte_value);
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bpsm_match_vec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpsm_match_vec
// Shift-and vector of partial matches and full-match detection.
// ----------------------------------------------------------------------------
module bpsm_match_vec #(
    parameter int PATTERN_MAX = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire bpsm_pkg::step_t   step,
    input  wire [PATTERN_MAX-1:0]  eq,
    output logic                   hit
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0] vec_reg;
    logic [PATTERN_MAX-1:0] vec_next;
    logic [PATTERN_MAX-1:0] eq_used;
    logic [PATTERN_MAX-1:0] shifted;
    logic [IDX_W-1:0]       hit_idx;

    // only positions below the pattern length take part
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_mask
        assign eq_used[i] = eq[i] && (32'(step.len) > 32'(i));
    end

    assign shifted = (vec_reg << 1) | PATTERN_MAX'(1);
    assign hit_idx = IDX_W'(step.len - bpsm_pkg::LEN_W'(1));
    assign hit     = step.data && step.len_ok && shifted[hit_idx] && eq_used[hit_idx];

    always_comb
    begin
        vec_next = vec_reg;
        if (step.restart)
        begin
            vec_next = '0;
        end
        else if (step.data)
        begin
            // a full match restarts the search after it
            if (!step.len_ok || hit)
            begin
                vec_next = '0;
            end
            else
            begin
                vec_next = shifted & eq_used;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg <= '0;
        end
        else
        begin
            vec_reg <= vec_next;
        end
    end

    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (vec_reg == '0))
        else $error("match vector not cleared after a match");

    a_bad_len_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step.data && !step.len_ok) |=> (vec_reg == '0))
        else $error("match vector set with unusable pattern length");

endmodule
`default_nettype wire

// ===== hw/rtl/byte_pattern_stream_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_pattern_stream_matcher
// Leftmost non-overlapping exact search of a loaded byte pattern in a stream.
// ----------------------------------------------------------------------------
// a data byte is registered in the input stage, and its match result then in the result register (m_tvalid)
// throughput: one item per cycle while the result output is not stalled; each byte is
// compared against every pattern position at once and the match vector updates in that same cycle
// reset clears offset, match count, match vector, pattern_length (to 1) and
// the pipeline valids; pattern bytes are not reset and must be loaded
module byte_pattern_stream_matcher #(
    parameter int PATTERN_MAX = 64
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // stream in
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire [bpsm_pkg::IN_DATA_W-1:0]        s_tdata,  // byte_value[7:0], pattern_index[13:8]
    input  wire [bpsm_pkg::MODE_W-1:0]           s_tuser,  // mode[1:0]
    // results out
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [bpsm_pkg::OUT_DATA_W-1:0]      m_tdata,  // match_offset[47:0], match_number[79:48]
    // configuration
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [bpsm_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire [bpsm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [bpsm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    // input stage
    logic                              s1_valid_reg;
    logic [bpsm_pkg::MODE_W-1:0]       s1_mode_reg;
    logic [bpsm_pkg::BYTE_W-1:0]       s1_byte_reg;
    logic [bpsm_pkg::PIDX_W-1:0]       s1_index_reg;

    logic [bpsm_pkg::LEN_W-1:0]        len_reg;
    logic [bpsm_pkg::OFFSET_W-1:0]     offset_reg;
    logic [bpsm_pkg::OFFSET_W-1:0]     offset_next;
    logic [bpsm_pkg::COUNT_W-1:0]      count_reg;
    logic [bpsm_pkg::COUNT_W-1:0]      count_next;
    logic [bpsm_pkg::COUNT_W-1:0]      count_inc;

    logic                              m_valid_reg;
    logic [bpsm_pkg::OFFSET_W-1:0]     m_offset_reg;
    logic [bpsm_pkg::COUNT_W-1:0]      m_number_reg;

    logic                              out_free;
    logic                              advance;
    logic                              hit;
    logic [PATTERN_MAX-1:0]            eq;
    bpsm_pkg::step_t                   step;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_comb
    begin
        step         = '0;
        step.len     = len_reg;
        step.len_ok  = (len_reg != '0) && (32'(len_reg) <= PATTERN_MAX);
        if (advance)
        begin
            case (s1_mode_reg)
                bpsm_pkg::MODE_LOAD:    step.load    = 1'b1;
                bpsm_pkg::MODE_DATA:    step.data    = 1'b1;
                bpsm_pkg::MODE_RESTART: step.restart = 1'b1;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_mode_reg  <= s_tuser;
            s1_byte_reg  <= s_tdata[7:0];
            s1_index_reg <= s_tdata[13:8];
        end
    end

    bpsm_pattern_store #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_store (
        .clk        (clk),
        .step       (step),
        .wr_index   (s1_index_reg),
        .byte_value (s1_byte_reg),
        .eq         (eq)
    );

    bpsm_match_vec #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .eq    (eq),
        .hit   (hit)
    );

    // offset and saturating match count
    assign count_inc = (count_reg == bpsm_pkg::COUNT_MAX) ? count_reg
                                                          : count_reg + 1'b1;

    always_comb
    begin
        offset_next = offset_reg;
        count_next  = count_reg;
        if (step.restart)
        begin
            offset_next = '0;
            count_next  = '0;
        end
        else if (step.data)
        begin
            offset_next = offset_reg + 1'b1;
            if (hit)
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            count_reg  <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= step.data && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step.data && hit)
        begin
            // start of match: current offset minus (length - 1), wrapping
            m_offset_reg <= offset_reg - bpsm_pkg::OFFSET_W'(len_reg) + 1'b1;
            m_number_reg <= count_inc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_number_reg, m_offset_reg};

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= bpsm_pkg::LEN_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == bpsm_pkg::ADDR_PATTERN_LENGTH))
        begin
            len_reg <= pwdata[bpsm_pkg::LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == bpsm_pkg::ADDR_PATTERN_LENGTH)
        begin
            prdata = bpsm_pkg::APB_DATA_W'(len_reg);
        end
    end

    a_result_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(s1_valid_reg && (s1_mode_reg == bpsm_pkg::MODE_DATA)))
        else $error("result produced without a data byte");

    a_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_number_reg != '0))
        else $error("match number zero on a result");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step.restart |=> ((offset_reg == '0) && (count_reg == '0)))
        else $error("restart did not clear offset and count");

    a_offset_steps: assert property (@(posedge clk) disable iff (!rst_n)
        step.data |=> (offset_reg == $past(offset_reg) + 1'b1))
        else $error("stream offset did not advance on a data byte");

endmodule
`default_nettype wire
